FILE: rtl/edqa_pkg.sv
`timescale 1ns / 1ps

package edqa_pkg;

    // queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // payload widths
    localparam int COUNT_W  = 16;
    localparam int DELTA_W  = 8;
    localparam int TOTAL_W  = 32;
    localparam int STEP_W   = 18;
    localparam int MAG_W    = 17;
    localparam int QFILL_W  = 3;

    // item codes
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_READ   = 1'b1;

    // reset reading and acceleration breakpoints
    localparam logic [COUNT_W-1:0] PREV_RESET = 16'h7fff;
    localparam logic [DELTA_W-1:0] ACCEL_LOW  = 8'd5;
    localparam logic [DELTA_W-1:0] ACCEL_MID  = 8'd10;
    localparam logic [MAG_W-1:0]   MUL_MID    = 17'd50;
    localparam logic [MAG_W-1:0]   MUL_HIGH   = 17'd1000;

    typedef logic signed [DELTA_W-1:0] t_delta;

    typedef struct packed {
        logic shift;   // take the neighbour's entry
        logic load;    // take the new delta
    } t_cell_ctrl;

endpackage

FILE: rtl/edqa_cell.sv
`timescale 1ns / 1ps

module edqa_cell (
    input  logic                i_clk,
    input  edqa_pkg::t_cell_ctrl i_ctrl,
    input  edqa_pkg::t_delta    i_new,
    input  edqa_pkg::t_delta    i_next,
    output edqa_pkg::t_delta    o_data
);
    import edqa_pkg::*;

    t_delta r_data;
    t_delta n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.load) begin
            n_data = i_new;
        end else if (i_ctrl.shift) begin
            n_data = i_next;
        end
    end

    // entry storage has no reset: never read before written
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

FILE: rtl/edqa_accel.sv
`timescale 1ns / 1ps

module edqa_accel (
    input  edqa_pkg::t_delta                    i_delta,
    output logic signed [edqa_pkg::STEP_W-1:0]  o_step
);
    import edqa_pkg::*;

    logic               w_neg;
    logic [DELTA_W-1:0] w_mag;
    logic [MAG_W-1:0]   w_scaled;

    always_comb begin
        w_neg = i_delta[DELTA_W-1];
        // magnitude of -128 is 128, still fits unsigned
        w_mag = w_neg ? (~i_delta + 1'b1) : i_delta;
        if (w_mag > ACCEL_MID) begin
            w_scaled = MAG_W'(w_mag - ACCEL_MID) * MUL_HIGH;
        end else begin
            w_scaled = MAG_W'(w_mag - ACCEL_LOW) * MUL_MID;
        end
        if (w_mag <= ACCEL_LOW) begin
            o_step = STEP_W'(i_delta);
        end else if (w_neg) begin
            o_step = -$signed({1'b0, w_scaled});
        end else begin
            o_step = $signed({1'b0, w_scaled});
        end
    end

endmodule

FILE: rtl/encoder_delta_queue_accel.sv
`timescale 1ns / 1ps

// rotary encoder delta queue with acceleration
// command channel: an item transfers on a rising edge with start high and busy
//   low; i_func selects a counter sample (0) or a read of one queued delta (1)
// a sample whose reading differs from the last one forms an 8-bit signed delta,
//   adds it to the wrapping 32-bit step total and pushes it into a row of
//   queue cells; a full row shifts out its oldest entry (o_dropped_oldest)
// a read pops the oldest cell and maps it through the acceleration rule:
//   small steps pass, medium steps give (|d| - 5) * 50, large (|d| - 10) * 1000
// result channel: o_done strobes for exactly one cycle, in the cycle after the
//   command transfer, with all result ports valid; the receiver cannot stall
// throughput: one item per cycle, busy stays low; the whole update (subtract,
//   total add, cell shift and the constant multiply of the head entry) is
//   combinational logic in front of the state and result registers
// reset (synchronous, active low) sets the last reading to 0x7fff, clears the
//   total and the fill count and drops any pending strobe; the queue cells keep
//   stale data, which is never read as the fill count gates every access
module encoder_delta_queue_accel (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_func,
    input  logic [edqa_pkg::COUNT_W-1:0]        i_counter_value,
    output logic                                o_done,
    output logic signed [edqa_pkg::STEP_W-1:0]  o_step_value,
    output logic                                o_step_valid,
    output logic signed [edqa_pkg::TOTAL_W-1:0] o_step_total,
    output logic [edqa_pkg::QFILL_W-1:0]        o_queue_fill,
    output logic                                o_dropped_oldest
);
    import edqa_pkg::*;

    // architectural state
    logic [COUNT_W-1:0] r_prev,  n_prev;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic [FILL_W-1:0]  r_fill,  n_fill;
    logic               r_done;

    // result registers, no reset needed
    logic signed [STEP_W-1:0] r_step;
    logic                     r_step_valid;
    logic                     r_dropped;
    logic [QFILL_W-1:0]       r_qfill;

    logic               w_take;
    logic               w_changed;
    logic               w_full;
    logic               w_push;
    logic               w_pop;
    logic [IDX_W-1:0]   w_push_idx;
    t_delta             w_delta;
    logic signed [STEP_W-1:0] w_accel;

    t_delta     w_cell_q [QUEUE_DEPTH];
    t_cell_ctrl w_ctrl   [QUEUE_DEPTH];

    assign busy   = 1'b0;
    assign w_take = start && !busy;

    assign w_changed  = (i_counter_value != r_prev);
    assign w_delta    = t_delta'(i_counter_value - r_prev);
    assign w_full     = (r_fill == FILL_W'(QUEUE_DEPTH));
    assign w_push     = w_take && (i_func == FUNC_SAMPLE) && w_changed;
    assign w_pop      = w_take && (i_func == FUNC_READ) && (r_fill != '0);
    // a full row shifts and the new delta lands in the tail cell
    assign w_push_idx = w_full ? IDX_W'(QUEUE_DEPTH - 1) : r_fill[IDX_W-1:0];

    // the row of queue cells, each handing its entry towards the head
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_delta w_next;

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign w_next = w_cell_q[g];
        end else begin : g_body
            assign w_next = w_cell_q[g + 1];
        end

        assign w_ctrl[g].shift = w_pop || (w_push && w_full);
        assign w_ctrl[g].load  = w_push && (w_push_idx == IDX_W'(g));

        edqa_cell u_cell (
            .i_clk  (i_clk),
            .i_ctrl (w_ctrl[g]),
            .i_new  (w_delta),
            .i_next (w_next),
            .o_data (w_cell_q[g])
        );
    end

    edqa_accel u_accel (
        .i_delta (w_cell_q[0]),
        .o_step  (w_accel)
    );

    always_comb begin
        n_prev  = r_prev;
        n_total = r_total;
        n_fill  = r_fill;
        if (w_push) begin
            n_prev  = i_counter_value;
            n_total = r_total + TOTAL_W'(w_delta);
            if (!w_full) begin
                n_fill = r_fill + 1'b1;
            end
        end else if (w_pop) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= PREV_RESET;
            r_total <= '0;
            r_fill  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_prev  <= n_prev;
            r_total <= n_total;
            r_fill  <= n_fill;
            r_done  <= w_take;
        end
    end

    // result capture on every command transfer
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_step       <= w_pop ? w_accel : '0;
            r_step_valid <= w_pop;
            r_dropped    <= w_push && w_full;
            r_qfill      <= QFILL_W'(n_fill);
        end
    end

    assign o_done           = r_done;
    assign o_step_value     = r_step;
    assign o_step_valid     = r_step_valid;
    assign o_step_total     = r_total;
    assign o_queue_fill     = r_qfill;
    assign o_dropped_oldest = r_dropped;

`ifndef SYNTHESIS
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> o_done)
        else $error("result strobe missing after command transfer");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(QUEUE_DEPTH))
        else $error("fill count beyond queue depth");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_dropped_oldest) |-> (r_fill == FILL_W'(QUEUE_DEPTH)))
        else $error("drop reported while queue not full");

    a_pop_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> (r_fill == $past(r_fill) - 1'b1))
        else $error("read did not lower fill count");

    a_valid_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_step_valid) |-> (o_step_value == '0))
        else $error("non-zero step without a popped entry");
`endif

endmodule
